@@ hw/rtl/sender_filtered_mailbox_macros.svh @@
// assertion macros for the mailbox block
// no dependencies; clocked on clk_i, reset rst_ni
`ifndef SENDER_FILTERED_MAILBOX_MACROS_SVH
`define SENDER_FILTERED_MAILBOX_MACROS_SVH

// checked only outside reset
`define SFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked during reset too
`define SFM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/sfm_pkg.sv @@
// shared types, constants and codes of the mailbox block
// no dependencies
package sfm_pkg;
  localparam int unsigned Slots = 16;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned PosW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned AddrW = SlotW + PosW;
  localparam int unsigned SrcW = $clog2(Slots + 1);

  localparam logic [2:0] StOk = 3'd0;
  localparam logic [2:0] StBadDest = 3'd1;
  localparam logic [2:0] StFull = 3'd2;
  localparam logic [2:0] StBadLen = 3'd3;
  localparam logic [2:0] StNoMatch = 3'd4;
  localparam logic [2:0] StBlocked = 3'd5;

  localparam logic CfgMaxPayload = 1'b0;
  localparam logic CfgQueueLimit = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_SEND, S_RD, S_CMP, S_SH_RD, S_SH_WR
  } state_e;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] mtype;
    logic [12:0] len;
    logic [3:0]  sender;
    logic [31:0] ref_h;
  } entry_t;

  typedef struct packed {
    logic load;
    logic send_exec;
    logic scan_rd;
    logic scan_cmp;
    logic recv_fail;
    logic shift_rd;
    logic shift_wr;
    logic recv_done;
  } cmd_t;

  typedef struct packed {
    logic is_recv;
    logic idx_end;
    logic next_end;
    logic match;
  } sts_t;
endpackage

@@ hw/rtl/sfm_ctrl.sv @@
// controller state machine of the mailbox block
// depends on sfm_pkg
module sfm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  sfm_pkg::sts_t sts_i,
  output sfm_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  sfm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sfm_pkg::S_IDLE: begin
        if (start_i) state_d = sfm_pkg::S_SEND;
      end
      sfm_pkg::S_SEND: begin
        if (sts_i.is_recv) state_d = sfm_pkg::S_RD;
        else state_d = sfm_pkg::S_IDLE;
      end
      sfm_pkg::S_RD: begin
        if (sts_i.idx_end) state_d = sfm_pkg::S_IDLE;
        else state_d = sfm_pkg::S_CMP;
      end
      sfm_pkg::S_CMP: begin
        if (sts_i.match) state_d = sfm_pkg::S_SH_RD;
        else state_d = sfm_pkg::S_RD;
      end
      sfm_pkg::S_SH_RD: begin
        if (sts_i.next_end) state_d = sfm_pkg::S_IDLE;
        else state_d = sfm_pkg::S_SH_WR;
      end
      sfm_pkg::S_SH_WR: state_d = sfm_pkg::S_SH_RD;
      default: state_d = sfm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = 1'b1;
    case (state_q)
      sfm_pkg::S_IDLE: begin
        busy_o = 1'b0;
        cmd_o.load = start_i;
      end
      sfm_pkg::S_SEND: cmd_o.send_exec = !sts_i.is_recv;
      sfm_pkg::S_RD: begin
        cmd_o.scan_rd = !sts_i.idx_end;
        cmd_o.recv_fail = sts_i.idx_end;
      end
      sfm_pkg::S_CMP: cmd_o.scan_cmp = 1'b1;
      sfm_pkg::S_SH_RD: begin
        cmd_o.shift_rd = !sts_i.next_end;
        cmd_o.recv_done = sts_i.next_end;
      end
      sfm_pkg::S_SH_WR: cmd_o.shift_wr = 1'b1;
      default: cmd_o = '0;
    endcase
  end
endmodule

@@ hw/rtl/sfm_datapath.sv @@
// datapath of the mailbox block: entry memory, queue counts, wait records, results
// depends on sfm_pkg and sender_filtered_mailbox_macros.svh
`include "sender_filtered_mailbox_macros.svh"
module sfm_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sfm_pkg::cmd_t              cmd_i,
  output sfm_pkg::sts_t              sts_o,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_index_i,
  input  logic [12:0]                cfg_data_i,
  input  logic                       action_i,
  input  logic [3:0]                 caller_i,
  input  logic [3:0]                 dest_i,
  input  logic                       dest_live_i,
  input  logic signed [31:0]         msg_id_i,
  input  logic signed [31:0]         msg_type_i,
  input  logic signed [31:0]         msg_len_i,
  input  logic [31:0]                payload_ref_i,
  input  logic [3:0]                 from_sender_i,
  input  logic                       any_sender_i,
  input  logic                       nonblock_i,
  output logic                       done_o,
  output logic [2:0]                 status_o,
  output logic signed [31:0]         out_id_o,
  output logic signed [31:0]         out_type_o,
  output logic [12:0]                out_len_o,
  output logic [3:0]                 out_sender_o,
  output logic [31:0]                out_payload_ref_o,
  output logic                       wake_o,
  output logic [3:0]                 wake_target_o
);
  localparam int unsigned SlotW = sfm_pkg::SlotW;
  localparam int unsigned PosW = sfm_pkg::PosW;
  localparam int unsigned CntW = sfm_pkg::CntW;
  localparam int unsigned SrcW = sfm_pkg::SrcW;

  sfm_pkg::entry_t mem [sfm_pkg::Slots * sfm_pkg::QueueDepth];
  sfm_pkg::entry_t rd_q;

  logic [CntW-1:0] cnt_q [sfm_pkg::Slots];
  logic [sfm_pkg::Slots-1:0] wait_q;
  logic [SrcW-1:0] src_q [sfm_pkg::Slots];
  logic [12:0] max_q;
  logic [4:0] lim_q;

  logic action_q, live_q, any_q, nb_q;
  logic [SlotW-1:0] caller_q, dest_q, from_q;
  logic [31:0] id_q, type_q, len_q, ref_q;
  logic [CntW-1:0] idx_q;

  logic done_q;
  logic [2:0] status_q;
  sfm_pkg::entry_t res_q;
  logic wake_q;
  logic [SlotW-1:0] wtgt_q;

  logic [CntW-1:0] lim, cnt_dst, cnt_own, idx_nx;
  logic send_ok, wake_hit;
  logic [2:0] send_st;

  always_comb begin
    lim = (lim_q > 5'(sfm_pkg::QueueDepth)) ? CntW'(sfm_pkg::QueueDepth) : CntW'(lim_q);
    cnt_dst = cnt_q[dest_q];
    cnt_own = cnt_q[caller_q];
    idx_nx = idx_q + CntW'(1);
    if (!live_q || dest_q == caller_q) send_st = sfm_pkg::StBadDest;
    else if (cnt_dst >= lim) send_st = sfm_pkg::StFull;
    else if (len_q[31] || len_q > {19'd0, max_q}) send_st = sfm_pkg::StBadLen;
    else send_st = sfm_pkg::StOk;
    send_ok = (send_st == sfm_pkg::StOk);
    wake_hit = wait_q[dest_q] &&
               (src_q[dest_q] == SrcW'(sfm_pkg::Slots) || src_q[dest_q] == SrcW'(caller_q));
    sts_o.is_recv = action_q;
    sts_o.idx_end = (idx_q >= cnt_own);
    sts_o.next_end = (idx_nx >= cnt_own);
    sts_o.match = any_q || (rd_q.sender == from_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.send_exec && send_ok) begin
      mem[{dest_q, cnt_dst[PosW-1:0]}] <= '{id: id_q, mtype: type_q, len: len_q[12:0],
                                            sender: caller_q, ref_h: ref_q};
    end
    if (cmd_i.shift_wr) mem[{caller_q, idx_q[PosW-1:0]}] <= rd_q;
    if (cmd_i.scan_rd) rd_q <= mem[{caller_q, idx_q[PosW-1:0]}];
    else if (cmd_i.shift_rd) rd_q <= mem[{caller_q, idx_nx[PosW-1:0]}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      action_q <= 1'b0;
      caller_q <= '0;
      dest_q <= '0;
      live_q <= 1'b0;
      id_q <= '0;
      type_q <= '0;
      len_q <= '0;
      ref_q <= '0;
      from_q <= '0;
      any_q <= 1'b0;
      nb_q <= 1'b0;
    end else if (cmd_i.load) begin
      action_q <= action_i;
      caller_q <= caller_i;
      dest_q <= dest_i;
      live_q <= dest_live_i;
      id_q <= msg_id_i;
      type_q <= msg_type_i;
      len_q <= msg_len_i;
      ref_q <= payload_ref_i;
      from_q <= from_sender_i;
      any_q <= any_sender_i;
      nb_q <= nonblock_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < sfm_pkg::Slots; s++) begin
        cnt_q[s] <= '0;
        src_q[s] <= '0;
      end
      wait_q <= '0;
      max_q <= 13'd4096;
      lim_q <= 5'd16;
      idx_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.send_exec || cmd_i.recv_fail || cmd_i.recv_done;
      if (cfg_valid_i) begin
        if (cfg_index_i == sfm_pkg::CfgMaxPayload) max_q <= cfg_data_i;
        else lim_q <= cfg_data_i[4:0];
      end
      if (cmd_i.load) idx_q <= '0;
      if (cmd_i.scan_cmp && !sts_o.match) idx_q <= idx_nx;
      if (cmd_i.shift_wr) idx_q <= idx_nx;
      if (cmd_i.send_exec && send_ok) begin
        cnt_q[dest_q] <= cnt_dst + CntW'(1);
        if (wake_hit) wait_q[dest_q] <= 1'b0;
      end
      if (cmd_i.recv_fail && !nb_q) begin
        wait_q[caller_q] <= 1'b1;
        src_q[caller_q] <= any_q ? SrcW'(sfm_pkg::Slots) : SrcW'(from_q);
      end
      if (cmd_i.recv_done) cnt_q[caller_q] <= cnt_own - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.send_exec) begin
      status_q <= send_st;
      res_q <= '0;
      wake_q <= send_ok && wake_hit;
      wtgt_q <= (send_ok && wake_hit) ? dest_q : '0;
    end
    if (cmd_i.recv_fail) begin
      status_q <= nb_q ? sfm_pkg::StNoMatch : sfm_pkg::StBlocked;
      res_q <= '0;
      wake_q <= 1'b0;
      wtgt_q <= '0;
    end
    if (cmd_i.scan_cmp && sts_o.match) begin
      res_q <= rd_q;
    end
    if (cmd_i.recv_done) begin
      status_q <= sfm_pkg::StOk;
      wake_q <= 1'b0;
      wtgt_q <= '0;
    end
  end

  assign done_o = done_q;
  assign status_o = status_q;
  assign out_id_o = res_q.id;
  assign out_type_o = res_q.mtype;
  assign out_len_o = res_q.len;
  assign out_sender_o = res_q.sender;
  assign out_payload_ref_o = res_q.ref_h;
  assign wake_o = wake_q;
  assign wake_target_o = wtgt_q;

  `SFM_ASSERT(a_done_single, done_q |=> !done_q, "result strobe held two cycles")
  `SFM_ASSERT(a_wake_ok, (done_q && wake_q) |-> (status_q == sfm_pkg::StOk), "wake on failure")
  `SFM_ASSERT(a_cnt_bound, cnt_own <= CntW'(sfm_pkg::QueueDepth), "queue count overflow")
  `SFM_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !done_q || rst_ni, "strobe out of reset")
endmodule

@@ hw/rtl/sender_filtered_mailbox.sv @@
// Mailbox with one message queue per slot; send appends, receive takes the
// first entry matching the sender filter. Send: the request is registered,
// then executed in S_SEND, and its result is registered. Receive: queued entries
// are scanned through the single-port entry memory; after a match the gap is closed.
// One item at a time; results cannot be stalled. Async reset empties queues.
module sender_filtered_mailbox (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [12:0]        cfg_data_i,
  input  logic               action_i,
  input  logic [3:0]         caller_i,
  input  logic [3:0]         dest_i,
  input  logic               dest_live_i,
  input  logic signed [31:0] msg_id_i,
  input  logic signed [31:0] msg_type_i,
  input  logic signed [31:0] msg_len_i,
  input  logic [31:0]        payload_ref_i,
  input  logic [3:0]         from_sender_i,
  input  logic               any_sender_i,
  input  logic               nonblock_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic signed [31:0] out_id_o,
  output logic signed [31:0] out_type_o,
  output logic [12:0]        out_len_o,
  output logic [3:0]         out_sender_o,
  output logic [31:0]        out_payload_ref_o,
  output logic               wake_o,
  output logic [3:0]         wake_target_o
);
  sfm_pkg::cmd_t cmd;
  sfm_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  sfm_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .sts_i(sts), .cmd_o(cmd), .busy_o
  );

  sfm_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .action_i, .caller_i, .dest_i, .dest_live_i, .msg_id_i, .msg_type_i,
    .msg_len_i, .payload_ref_i, .from_sender_i, .any_sender_i, .nonblock_i,
    .done_o, .status_o, .out_id_o, .out_type_o, .out_len_o, .out_sender_o,
    .out_payload_ref_o, .wake_o, .wake_target_o
  );
endmodule

@@ sim/tb_top.sv @@
// testbench for the sender-filtered mailbox: directed table, then random sends and receives
// depends on sfm_pkg and sender_filtered_mailbox; self-checking against an in-bench predictor
`timescale 1ns / 100ps

module tb_top;
  localparam logic ActSend = 1'b0;
  localparam logic ActRecv = 1'b1;
  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned RandItems = 1300;

  typedef struct {
    logic        act;
    logic [3:0]  caller;
    logic [3:0]  dest;
    logic        live;
    logic [31:0] id;
    logic [31:0] mtype;
    logic [31:0] len;
    logic [31:0] ref_h;
    logic [3:0]  from;
    logic        any;
    logic        nb;
  } req_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] id;
    logic [31:0] mtype;
    logic [12:0] len;
    logic [3:0]  sender;
    logic [31:0] ref_h;
    logic        wake;
    logic [3:0]  tgt;
  } reply_t;

  typedef struct {
    req_t       rq;
    bit         typed;
    logic [2:0] st;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [12:0] cfg_data_i = '0;
  logic action_i = 1'b0;
  logic [3:0] caller_i = '0;
  logic [3:0] dest_i = '0;
  logic dest_live_i = 1'b0;
  logic signed [31:0] msg_id_i = '0;
  logic signed [31:0] msg_type_i = '0;
  logic signed [31:0] msg_len_i = '0;
  logic [31:0] payload_ref_i = '0;
  logic [3:0] from_sender_i = '0;
  logic any_sender_i = 1'b0;
  logic nonblock_i = 1'b0;
  logic done_o;
  logic [2:0] status_o;
  logic signed [31:0] out_id_o;
  logic signed [31:0] out_type_o;
  logic [12:0] out_len_o;
  logic [3:0] out_sender_o;
  logic [31:0] out_payload_ref_o;
  logic wake_o;
  logic [3:0] wake_target_o;

  sender_filtered_mailbox i_dut (.*);

  always #5 clk_i = ~clk_i;

  // mailbox shadow state
  sfm_pkg::entry_t mbox_q[sfm_pkg::Slots][sfm_pkg::QueueDepth];
  logic [4:0]  mbox_cnt[sfm_pkg::Slots];
  logic        mbox_wait[sfm_pkg::Slots];
  logic [4:0]  mbox_src[sfm_pkg::Slots];
  logic [12:0] max_pl;
  logic [4:0]  q_lim;

  reply_t reply_q[$];
  int unsigned err_cnt = 0;
  int unsigned status_seen[8];
  int unsigned wake_seen = 0;
  int unsigned idle_cyc = 0;
  bit gaps_on = 1'b1;

  function automatic reply_t mbox_predict(input req_t rq);
    reply_t r;
    int unsigned lim;
    int unsigned n;
    int unsigned hit;
    r = '{default: '0};
    lim = (q_lim > sfm_pkg::QueueDepth) ? sfm_pkg::QueueDepth : q_lim;
    if (rq.act == ActSend) begin
      if (!rq.live || rq.dest == rq.caller) begin
        r.status = sfm_pkg::StBadDest;
      end else if (mbox_cnt[rq.dest] >= lim) begin
        r.status = sfm_pkg::StFull;
      end else if (rq.len[31] || rq.len > max_pl) begin
        r.status = sfm_pkg::StBadLen;
      end else begin
        mbox_q[rq.dest][mbox_cnt[rq.dest]] = '{id: rq.id, mtype: rq.mtype, len: rq.len[12:0],
                                              sender: rq.caller, ref_h: rq.ref_h};
        mbox_cnt[rq.dest]++;
        r.status = sfm_pkg::StOk;
        if (mbox_wait[rq.dest] &&
            (mbox_src[rq.dest] == sfm_pkg::Slots || mbox_src[rq.dest] == rq.caller))
        begin
          mbox_wait[rq.dest] = 1'b0;
          r.wake = 1'b1;
          r.tgt = rq.dest;
        end
      end
    end else begin
      n = mbox_cnt[rq.caller];
      hit = n;
      for (int i = n - 1; i >= 0; i--) begin
        if (rq.any || mbox_q[rq.caller][i].sender == rq.from) hit = i;
      end
      if (hit == n) begin
        if (rq.nb) begin
          r.status = sfm_pkg::StNoMatch;
        end else begin
          mbox_wait[rq.caller] = 1'b1;
          mbox_src[rq.caller] = rq.any ? 5'(sfm_pkg::Slots) : 5'(rq.from);
          r.status = sfm_pkg::StBlocked;
        end
      end else begin
        r.status = sfm_pkg::StOk;
        r.id = mbox_q[rq.caller][hit].id;
        r.mtype = mbox_q[rq.caller][hit].mtype;
        r.len = mbox_q[rq.caller][hit].len;
        r.sender = mbox_q[rq.caller][hit].sender;
        r.ref_h = mbox_q[rq.caller][hit].ref_h;
        for (int k = hit; k + 1 < n; k++) mbox_q[rq.caller][k] = mbox_q[rq.caller][k + 1];
        mbox_cnt[rq.caller]--;
      end
    end
    return r;
  endfunction

  function automatic req_t mk_send(input logic [3:0] c, input logic [3:0] d, input logic lv,
                                   input logic [31:0] id, input logic [31:0] ty,
                                   input logic [31:0] ln, input logic [31:0] rf);
    req_t rq;
    rq = '{default: '0};
    rq.act = ActSend;
    rq.caller = c;
    rq.dest = d;
    rq.live = lv;
    rq.id = id;
    rq.mtype = ty;
    rq.len = ln;
    rq.ref_h = rf;
    return rq;
  endfunction

  function automatic req_t mk_recv(input logic [3:0] c, input logic [3:0] f, input logic an,
                                   input logic nbk);
    req_t rq;
    rq = '{default: '0};
    rq.act = ActRecv;
    rq.caller = c;
    rq.from = f;
    rq.any = an;
    rq.nb = nbk;
    rq.dest = 4'($urandom);
    rq.id = $urandom;
    return rq;
  endfunction

  function automatic logic [3:0] pick_slot();
    return ($urandom_range(99) < 70) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
  endfunction

  function automatic req_t rand_req();
    req_t rq;
    int unsigned sel;
    rq.act = 1'($urandom_range(1));
    rq.caller = pick_slot();
    rq.dest = pick_slot();
    rq.live = ($urandom_range(99) < 90);
    rq.id = $urandom;
    rq.mtype = $urandom;
    rq.ref_h = $urandom;
    rq.from = pick_slot();
    rq.any = 1'($urandom_range(1));
    rq.nb = 1'($urandom_range(1));
    sel = $urandom_range(99);
    if (sel < 65) rq.len = $urandom_range(max_pl);
    else if (sel < 75) rq.len = 32'(max_pl) + $urandom_range(1);
    else if (sel < 88) rq.len = $urandom;
    else rq.len = $urandom_range(16);
    return rq;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    err_cnt++;
    $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
  endtask

  task automatic issue(input req_t rq, input bit typed, input logic [2:0] st);
    reply_t r;
    while (gaps_on && $urandom_range(99) < 11) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    action_i <= rq.act;
    caller_i <= rq.caller;
    dest_i <= rq.dest;
    dest_live_i <= rq.live;
    msg_id_i <= rq.id;
    msg_type_i <= rq.mtype;
    msg_len_i <= rq.len;
    payload_ref_i <= rq.ref_h;
    from_sender_i <= rq.from;
    any_sender_i <= rq.any;
    nonblock_i <= rq.nb;
    do @(posedge clk_i); while (busy_o);
    r = mbox_predict(rq);
    if (typed) begin
      r = '{default: '0};
      r.status = st;
    end
    reply_q.push_back(r);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [12:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx == sfm_pkg::CfgMaxPayload) max_pl = val;
    else q_lim = val[4:0];
  endtask

  // result beat checker
  always @(posedge clk_i) begin
    reply_t w;
    if (rst_ni && done_o) begin
      if (reply_q.size() == 0) begin
        report("unexpected result", status_o, 0);
      end else begin
        w = reply_q.pop_front();
        status_seen[status_o]++;
        if (wake_o) wake_seen++;
        if (status_o !== w.status) report("status", status_o, w.status);
        if (out_id_o !== w.id) report("out_id", out_id_o, w.id);
        if (out_type_o !== w.mtype) report("out_type", out_type_o, w.mtype);
        if (out_len_o !== w.len) report("out_len", out_len_o, w.len);
        if (out_sender_o !== w.sender) report("out_sender", out_sender_o, w.sender);
        if (out_payload_ref_o !== w.ref_h) report("out_payload_ref", out_payload_ref_o, w.ref_h);
        if (wake_o !== w.wake) report("wake", wake_o, w.wake);
        if (wake_target_o !== w.tgt) report("wake_target", wake_target_o, w.tgt);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= IdleLimit) begin
      $display("timeout after %0d idle cycles", idle_cyc);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    dir_row_t dir[$];
    logic [12:0] pl_set[5];
    logic [12:0] lim_set[5];
    for (int s = 0; s < sfm_pkg::Slots; s++) begin
      mbox_cnt[s] = '0;
      mbox_wait[s] = 1'b0;
      mbox_src[s] = '0;
    end
    max_pl = 13'd4096;
    q_lim = 5'd16;

    dir.push_back('{mk_recv(3, 0, 1, 1), 1, sfm_pkg::StNoMatch});
    dir.push_back('{mk_send(1, 1, 1, 1, 1, 4, 1), 1, sfm_pkg::StBadDest});
    dir.push_back('{mk_send(1, 3, 0, 1, 1, 4, 1), 1, sfm_pkg::StBadDest});
    dir.push_back('{mk_send(1, 3, 1, 1, 1, 32'hffff_ffff, 1), 1, sfm_pkg::StBadLen});
    dir.push_back('{mk_send(1, 3, 1, 1, 1, 32'h8000_0000, 1), 1, sfm_pkg::StBadLen});
    dir.push_back('{mk_send(1, 3, 1, 1, 1, 4097, 1), 1, sfm_pkg::StBadLen});
    dir.push_back('{mk_send(1, 3, 1, 32'h7fff_ffff, 32'h8000_0000, 4096, 32'hffff_ffff), 0, 0});
    dir.push_back('{mk_send(2, 3, 1, 32'h8000_0000, 32'h7fff_ffff, 0, 0), 0, 0});
    dir.push_back('{mk_send(1, 3, 1, 32'hffff_ffff, 0, 5, 32'h1234_5678), 0, 0});
    dir.push_back('{mk_recv(3, 2, 0, 0), 0, 0});
    dir.push_back('{mk_recv(3, 0, 1, 0), 0, 0});
    dir.push_back('{mk_recv(3, 15, 0, 1), 1, sfm_pkg::StNoMatch});
    dir.push_back('{mk_recv(3, 15, 0, 0), 0, 0});
    dir.push_back('{mk_send(1, 3, 1, 7, 7, 7, 7), 0, 0});
    dir.push_back('{mk_send(15, 3, 1, 8, 8, 8, 8), 0, 0});
    dir.push_back('{mk_recv(0, 0, 1, 0), 0, 0});
    dir.push_back('{mk_recv(0, 0, 1, 0), 0, 0});
    dir.push_back('{mk_send(15, 0, 1, 9, 9, 9, 9), 0, 0});
    dir.push_back('{mk_recv(0, 15, 0, 1), 0, 0});
    dir.push_back('{mk_recv(3, 15, 0, 0), 0, 0});
    dir.push_back('{mk_recv(3, 0, 1, 1), 0, 0});
    dir.push_back('{mk_recv(3, 0, 1, 1), 0, 0});
    dir.push_back('{mk_send(0, 15, 1, 1, 2, 3, 4), 0, 0});
    dir.push_back('{mk_recv(15, 0, 0, 0), 0, 0});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir[i]) issue(dir[i].rq, dir[i].typed, dir[i].st);
    settle();

    pl_set = '{13'd4096, 13'd0, 13'd8191, 13'd100, 13'd4095};
    lim_set = '{13'd16, 13'd1, 13'd31, 13'd0, 13'd3};
    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(sfm_pkg::CfgMaxPayload, pl_set[ph]);
      cfg_write(sfm_pkg::CfgQueueLimit, lim_set[ph]);
      for (int n = 0; n < RandItems / 5; n++) begin
        gaps_on = !(ph == 2 && n >= 60 && n < 200);
        issue(rand_req(), 0, 0);
      end
      settle();
    end

    $display("items: ok %0d, bad dest %0d, full %0d, bad length %0d, no match %0d, blocked %0d",
             status_seen[sfm_pkg::StOk], status_seen[sfm_pkg::StBadDest],
             status_seen[sfm_pkg::StFull], status_seen[sfm_pkg::StBadLen],
             status_seen[sfm_pkg::StNoMatch], status_seen[sfm_pkg::StBlocked]);
    $display("wakes %0d, five register settings incl. zero and saturated limits", wake_seen);
    if (err_cnt == 0 && reply_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
